@@ hw/rtl/serw_pkg.sv @@
// ----------------------------------------------------------------------------
// serw_pkg
// Shared constants, types and helpers of the sequenced event reorder window.
// ----------------------------------------------------------------------------
package serw_pkg;

   localparam int WINDOW_SLOTS = 32;
   localparam int MAX_REQUESTS = 16;
   localparam int PAYLOAD_BITS = 32;

   localparam int SEQ_BITS   = 32;
   localparam int WORD_BITS  = 32;
   localparam int SLOT_BITS  = $clog2(WINDOW_SLOTS);
   localparam int USED_BITS  = $clog2(WINDOW_SLOTS + 1);
   localparam int REQ_BITS   = $clog2(MAX_REQUESTS + 1);
   localparam int STORE_BITS = (PAYLOAD_BITS < WORD_BITS) ? PAYLOAD_BITS : WORD_BITS;

   typedef logic [SLOT_BITS-1:0] slot_type;
   typedef logic [USED_BITS-1:0] used_type;
   typedef logic [REQ_BITS-1:0]  req_cnt_type;

   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_DELIVER = 2'd1;
   localparam logic [1:0] KIND_REQUEST = 2'd2;

   localparam logic [1:0] ST_STORED    = 2'd0;
   localparam logic [1:0] ST_DUPLICATE = 2'd1;
   localparam logic [1:0] ST_OLDER     = 2'd2;
   localparam logic [1:0] ST_BEYOND    = 2'd3;

   localparam logic REQ_ARRIVAL = 1'b0;
   localparam logic REQ_TICK    = 1'b1;

   typedef struct packed {
      logic arrive;
      logic release_word;
      logic tick_start;
      logic dlv_issue;
      logic dlv_capture;
      logic gap_mark;
      logic gap_step;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic held_valid;
      logic held_tick;
      logic off_lt_used;
      logic slot_full_off;
      logic req_below_max;
      logic pend_valid;
      logic out_free;
   } sts_type;

   function automatic slot_type phys_slot(slot_type ptr, used_type off);
      logic [USED_BITS:0] sum;
      sum = {1'b0, used_type'(ptr)} + {1'b0, off};
      if (sum >= (USED_BITS + 1)'(WINDOW_SLOTS)) begin
         sum = sum - (USED_BITS + 1)'(WINDOW_SLOTS);
      end
      return slot_type'(sum);
   endfunction

endpackage

@@ hw/rtl/serw_ram.sv @@
// ----------------------------------------------------------------------------
// serw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module serw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/serw_ctrl.sv @@
// ----------------------------------------------------------------------------
// serw_ctrl
// Sequencer for arrivals and for the deliver, gap scan and flush steps of a tick.
// ----------------------------------------------------------------------------
module serw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  serw_pkg::sts_type sts,
   output serw_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DLV_CHK,
      S_DLV_CAP,
      S_GAP,
      S_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      push_ok;

   assign push_ok = !sts.pend_valid || sts.out_free;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (sts.held_valid && !sts.held_tick && sts.out_free) begin
               cmd.arrive       = 1'b1;
               cmd.release_word = 1'b1;
            end else if (sts.held_valid && sts.held_tick) begin
               cmd.tick_start = 1'b1;
               state_in       = S_DLV_CHK;
            end
         end
         S_DLV_CHK: begin
            if (sts.off_lt_used && sts.slot_full_off) begin
               if (push_ok) begin
                  cmd.dlv_issue = 1'b1;
                  state_in      = S_DLV_CAP;
               end
            end else begin
               cmd.gap_mark = 1'b1;
               state_in     = S_GAP;
            end
         end
         S_DLV_CAP: begin
            cmd.dlv_capture = 1'b1;
            state_in        = S_DLV_CHK;
         end
         S_GAP: begin
            if (sts.off_lt_used && sts.req_below_max) begin
               if (push_ok) begin
                  cmd.gap_step = 1'b1;
               end
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (push_ok) begin
               cmd.flush        = 1'b1;
               cmd.release_word = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/serw_datapath.sv @@
// ----------------------------------------------------------------------------
// serw_datapath
// Input word buffer, window state, slot store, pending and output registers.
// ----------------------------------------------------------------------------
module serw_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  serw_pkg::cmd_type                cmd,
   output serw_pkg::sts_type                sts,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic [serw_pkg::SEQ_BITS-1:0]    req_seq_number,
   input  logic [serw_pkg::WORD_BITS-1:0]   req_event_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_result_kind,
   output logic [serw_pkg::SEQ_BITS-1:0]    rsp_result_seq,
   output logic [serw_pkg::WORD_BITS-1:0]   rsp_result_payload,
   output logic [1:0]                       rsp_arrival_status,
   output logic                             rsp_last_result
);

   localparam int W = serw_pkg::WINDOW_SLOTS;

   logic                             held_valid_ff, held_valid_in;
   logic                             held_type_ff;
   logic [serw_pkg::SEQ_BITS-1:0]    held_seq_ff;
   logic [serw_pkg::WORD_BITS-1:0]   held_pay_ff;
   logic                             accept;

   logic [W-1:0]                     full_ff, full_in;
   logic [serw_pkg::SEQ_BITS-1:0]    base_ff, base_in;
   serw_pkg::used_type               used_ff, used_in;
   serw_pkg::slot_type               ptr_ff, ptr_in;

   serw_pkg::used_type               off_ff, off_in;
   serw_pkg::used_type               n_ff, n_in;
   serw_pkg::req_cnt_type            req_cnt_ff, req_cnt_in;

   logic                             pend_valid_ff, pend_valid_in;
   logic [1:0]                       pend_kind_ff, pend_kind_in;
   logic [serw_pkg::SEQ_BITS-1:0]    pend_seq_ff, pend_seq_in;
   logic [serw_pkg::WORD_BITS-1:0]   pend_pay_ff, pend_pay_in;

   logic                             out_valid_ff, out_valid_in;
   logic [1:0]                       out_kind_ff, out_kind_in;
   logic [serw_pkg::SEQ_BITS-1:0]    out_seq_ff, out_seq_in;
   logic [serw_pkg::WORD_BITS-1:0]   out_pay_ff, out_pay_in;
   logic [1:0]                       out_status_ff, out_status_in;
   logic                             out_last_ff, out_last_in;

   logic [serw_pkg::SEQ_BITS-1:0]    arr_off;
   serw_pkg::used_type               arr_off_u;
   serw_pkg::slot_type               arr_slot;
   logic [1:0]                       arr_status;
   serw_pkg::slot_type               scan_slot;
   logic                             ram_wr_en;
   logic [serw_pkg::STORE_BITS-1:0]  ram_rd_data;
   logic                             out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = !held_valid_ff || cmd.release_word;
   assign accept    = req_valid && req_ready;
   assign scan_slot = serw_pkg::phys_slot(ptr_ff, off_ff);

   always_comb begin
      arr_off   = held_seq_ff - base_ff;
      arr_off_u = serw_pkg::used_type'(arr_off);
      arr_slot  = serw_pkg::phys_slot(ptr_ff, arr_off_u);
      if (held_seq_ff < base_ff) begin
         arr_status = serw_pkg::ST_OLDER;
      end else if (arr_off >= serw_pkg::SEQ_BITS'(W)) begin
         arr_status = serw_pkg::ST_BEYOND;
      end else if (full_ff[arr_slot]) begin
         arr_status = serw_pkg::ST_DUPLICATE;
      end else begin
         arr_status = serw_pkg::ST_STORED;
      end
   end

   assign ram_wr_en = cmd.arrive && (arr_status == serw_pkg::ST_STORED);

   serw_ram #(
      .WIDTH (serw_pkg::STORE_BITS),
      .DEPTH (W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (arr_slot),
      .wr_data (serw_pkg::STORE_BITS'(held_pay_ff)),
      .rd_en   (cmd.dlv_issue),
      .rd_addr (scan_slot),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      held_valid_in = held_valid_ff;
      if (accept) begin
         held_valid_in = 1'b1;
      end else if (cmd.release_word) begin
         held_valid_in = 1'b0;
      end

      full_in    = full_ff;
      base_in    = base_ff;
      used_in    = used_ff;
      ptr_in     = ptr_ff;
      off_in     = off_ff;
      n_in       = n_ff;
      req_cnt_in = req_cnt_ff;

      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_seq_in   = pend_seq_ff;
      pend_pay_in   = pend_pay_ff;

      out_valid_in  = out_valid_ff && !rsp_ready;
      out_kind_in   = out_kind_ff;
      out_seq_in    = out_seq_ff;
      out_pay_in    = out_pay_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      if (cmd.arrive) begin
         if (ram_wr_en) begin
            full_in[arr_slot] = 1'b1;
            if (used_ff < arr_off_u + 1'b1) begin
               used_in = arr_off_u + 1'b1;
            end
         end
         out_valid_in  = 1'b1;
         out_kind_in   = serw_pkg::KIND_STATUS;
         out_seq_in    = held_seq_ff;
         out_pay_in    = '0;
         out_status_in = arr_status;
         out_last_in   = 1'b1;
      end

      if (cmd.tick_start) begin
         off_in        = '0;
         req_cnt_in    = '0;
         pend_valid_in = 1'b0;
      end

      if (cmd.dlv_issue) begin
         full_in[scan_slot] = 1'b0;
      end

      if (cmd.gap_mark) begin
         n_in = off_ff;
      end

      if ((cmd.dlv_capture || (cmd.gap_step && !full_ff[scan_slot]) || cmd.flush)
          && pend_valid_ff) begin
         out_valid_in  = 1'b1;
         out_kind_in   = pend_kind_ff;
         out_seq_in    = pend_seq_ff;
         out_pay_in    = pend_pay_ff;
         out_status_in = serw_pkg::ST_STORED;
         out_last_in   = cmd.flush;
      end

      if (cmd.dlv_capture) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = serw_pkg::KIND_DELIVER;
         pend_seq_in   = base_ff + serw_pkg::SEQ_BITS'(off_ff);
         pend_pay_in   = serw_pkg::WORD_BITS'(ram_rd_data);
         off_in        = off_ff + 1'b1;
      end

      if (cmd.gap_step) begin
         if (!full_ff[scan_slot]) begin
            pend_valid_in = 1'b1;
            pend_kind_in  = serw_pkg::KIND_REQUEST;
            pend_seq_in   = base_ff + serw_pkg::SEQ_BITS'(off_ff);
            pend_pay_in   = '0;
            req_cnt_in    = req_cnt_ff + 1'b1;
         end
         off_in = off_ff + 1'b1;
      end

      if (cmd.flush) begin
         pend_valid_in = 1'b0;
         base_in       = base_ff + serw_pkg::SEQ_BITS'(n_ff);
         ptr_in        = serw_pkg::phys_slot(ptr_ff, n_ff);
         used_in       = used_ff - n_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         full_ff       <= '0;
         base_ff       <= '0;
         used_ff       <= '0;
         ptr_ff        <= '0;
         off_ff        <= '0;
         n_ff          <= '0;
         req_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         full_ff       <= full_in;
         base_ff       <= base_in;
         used_ff       <= used_in;
         ptr_ff        <= ptr_in;
         off_ff        <= off_in;
         n_ff          <= n_in;
         req_cnt_ff    <= req_cnt_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_type_ff <= req_type;
         held_seq_ff  <= req_seq_number;
         held_pay_ff  <= req_event_payload;
      end
      pend_kind_ff  <= pend_kind_in;
      pend_seq_ff   <= pend_seq_in;
      pend_pay_ff   <= pend_pay_in;
      out_kind_ff   <= out_kind_in;
      out_seq_ff    <= out_seq_in;
      out_pay_ff    <= out_pay_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   always_comb begin
      sts               = '0;
      sts.held_valid    = held_valid_ff;
      sts.held_tick     = (held_type_ff == serw_pkg::REQ_TICK);
      sts.off_lt_used   = (off_ff < used_ff);
      sts.slot_full_off = full_ff[scan_slot];
      sts.req_below_max = (req_cnt_ff < serw_pkg::REQ_BITS'(serw_pkg::MAX_REQUESTS));
      sts.pend_valid    = pend_valid_ff;
      sts.out_free      = out_free;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_kind    = out_kind_ff;
   assign rsp_result_seq     = out_seq_ff;
   assign rsp_result_payload = out_pay_ff;
   assign rsp_arrival_status = out_status_ff;
   assign rsp_last_result    = out_last_ff;

endmodule

@@ hw/rtl/sequenced_event_reorder_window.sv @@
// ----------------------------------------------------------------------------
// sequenced_event_reorder_window
// Reorder window for numbered events: stores arrivals by sequence number and,
// on a tick, delivers the run from the base and requests missing numbers.
//
//   channel | direction | words
//   req_    | in        | req_type, req_seq_number, req_event_payload
//   rsp_    | out       | kind, seq, payload, arrival status, last flag
//
// An arrival word is handled from the input buffer; arrivals run one a cycle
// while rsp_ is free. A tick reads the slot RAM for each delivered event, then
// scans the rest of the window for gaps and flushes; rsp_ready low stalls it.
// Reset is synchronous and empties the window at once, with no clearing pass.
// A one-word input buffer takes the next word while a result waits on rsp_.
// ----------------------------------------------------------------------------
module sequenced_event_reorder_window (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_type,
   input  logic [serw_pkg::SEQ_BITS-1:0]  req_seq_number,
   input  logic [serw_pkg::WORD_BITS-1:0] req_event_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_result_kind,
   output logic [serw_pkg::SEQ_BITS-1:0]  rsp_result_seq,
   output logic [serw_pkg::WORD_BITS-1:0] rsp_result_payload,
   output logic [1:0]                     rsp_arrival_status,
   output logic                           rsp_last_result
);

   serw_pkg::cmd_type cmd;
   serw_pkg::sts_type sts;

   serw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   serw_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_seq_number     (req_seq_number),
      .req_event_payload  (req_event_payload),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_result_seq     (rsp_result_seq),
      .rsp_result_payload (rsp_result_payload),
      .rsp_arrival_status (rsp_arrival_status),
      .rsp_last_result    (rsp_last_result)
   );

endmodule
